// File: rtl/core/sdmpwm_pkg.sv
// Shared types and constants for the sigma-delta PWM modulator core.
package sdmpwm_pkg;

	// Error integrator width (20..32).
	localparam int ACC_BITS = 24;

	localparam int SAMPLE_W = 16;
	localparam int LEVEL_W  = 16;
	localparam int LOG_W    = 4;
	// Residual spans -32768..65534.
	localparam int RESID_W  = 18;
	localparam int STEP_W   = 16;

	// Queue depth between front and back; keep it a power of two.
	localparam int Q_DEPTH  = 2;
	localparam int QPTR_W   = $clog2(Q_DEPTH);

	typedef enum logic {
		MODE_ONE_BIT = 1'b0,
		MODE_SD_PWM  = 1'b1
	} mode_t;

	typedef enum logic [1:0] {
		REG_MODE       = 2'd0,
		REG_LOG_STEPS  = 2'd1,
		REG_FULL_LEVEL = 2'd2
	} reg_idx_t;

	typedef struct packed {
		mode_t              mode;
		logic [LOG_W-1:0]   log_steps;
		logic [LEVEL_W-1:0] full_level;
	} cfg_t;

	// One classified item: residual, integrator step and the two candidate levels.
	typedef struct packed {
		logic [RESID_W-1:0] resid;
		logic [STEP_W-1:0]  step;
		logic [LEVEL_W-1:0] level_lo;
		logic [LEVEL_W-1:0] level_hi;
	} qent_t;

	typedef struct packed {
		logic empty;
		logic full;
	} qstat_t;

endpackage

// File: rtl/core/sigma_delta_pwm_modulator_core.sv
// Top level of the first-order sigma-delta PWM modulator.
//
//  channel  direction  handshake             payload
//  s_*      in         s_tvalid / s_tready   s_tdata[15:0] sample (signed)
//  m_*      out        m_tvalid / m_tready   m_tdata[15:0] level, [16] dither_high
//  cfg_*    in         cfg_valid / cfg_ready cfg_index[1:0], cfg_data[15:0]
//
// One item per cycle sustained while m_tready is held high; an accepted item is
// first written into the queue, then, once the output register is free, goes
// through the integrator add-compare into the output register. The integrator
// loop is a single registered add/compare/saturate.
// Reset clears the integrator, the queue and the output valid, and loads the
// default configuration. Input stalls only when the two-entry queue is full.
module sigma_delta_pwm_modulator_core
	import sdmpwm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [SAMPLE_W-1:0] s_tdata,   // [15:0] sample
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [23:0]         m_tdata,   // [15:0] level, [16] dither_high, [23:17] zero
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data
);

	cfg_t   cfg_q;
	qent_t  entry;
	qent_t  head;
	qstat_t q_stat;
	logic   push;
	logic   pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode       <= MODE_SD_PWM;
			cfg_q.log_steps  <= LOG_W'(5);
			cfg_q.full_level <= LEVEL_W'(32);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MODE:       cfg_q.mode       <= mode_t'(cfg_data[0]);
				REG_LOG_STEPS:  cfg_q.log_steps  <= cfg_data[LOG_W-1:0];
				REG_FULL_LEVEL: cfg_q.full_level <= cfg_data[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	sdmpwm_front u_front (
		.cfg      (cfg_q),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_stat.full),
		.push     (push),
		.entry    (entry)
	);

	sdmpwm_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (entry),
		.pop     (pop),
		.rd_data (head),
		.stat    (q_stat)
	);

	sdmpwm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_empty  (q_stat.empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Queue can never look empty and full together.
	a_q_stat: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.empty && q_stat.full))
		else $error("queue status inconsistent");

	// An item written into an empty queue is visible there next cycle.
	a_q_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && q_stat.empty) |=> !q_stat.empty)
		else $error("accepted item lost in queue");

	// In one-bit mode a low decision always outputs level zero.
	a_one_bit_low: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && cfg_q.mode == MODE_ONE_BIT && !m_tdata[16]) |-> (m_tdata[15:0] == '0))
		else $error("one-bit mode low item with nonzero level");

endmodule

// File: rtl/core/sdmpwm_front.sv
// Front end: accepts samples and splits them into residual, step and candidate levels.
module sdmpwm_front
	import sdmpwm_pkg::*;
(
	input  cfg_t                cfg,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [SAMPLE_W-1:0] s_tdata,   // [15:0] sample (signed)
	input  logic                q_full,
	output logic                push,
	output qent_t               entry
);

	logic [SAMPLE_W-1:0] u;
	logic [4:0]          shift;
	logic [LEVEL_W-1:0]  coarse_raw;
	logic [LEVEL_W-1:0]  limit;
	logic [LEVEL_W-1:0]  coarse;
	logic [LEVEL_W-1:0]  base;
	logic [STEP_W-1:0]   pwm_step;

	assign s_tready = !q_full;
	assign push     = s_tvalid && !q_full;

	// Offset binary: sample + 32768.
	assign u          = {~s_tdata[SAMPLE_W-1], s_tdata[SAMPLE_W-2:0]};
	assign shift      = 5'd16 - {1'b0, cfg.log_steps};
	assign coarse_raw = LEVEL_W'(u >> shift);
	assign limit      = (cfg.full_level == '0) ? '0 : cfg.full_level - LEVEL_W'(1);
	assign coarse     = (coarse_raw > limit) ? limit : coarse_raw;
	// coarse never exceeds u >> shift, so the shifted value fits in 16 bits.
	assign base       = LEVEL_W'(coarse << shift);
	assign pwm_step   = STEP_W'(16'd1 << (shift - 5'd1));

	always_comb begin
		unique case (cfg.mode)
			MODE_ONE_BIT: begin
				entry.resid    = {{(RESID_W-SAMPLE_W){s_tdata[SAMPLE_W-1]}}, s_tdata};
				entry.step     = STEP_W'(16'h8000);
				entry.level_lo = '0;
				entry.level_hi = cfg.full_level;
			end
			default: begin
				entry.resid    = {{(RESID_W-SAMPLE_W){1'b0}}, u}
				               - {{(RESID_W-LEVEL_W){1'b0}}, base}
				               - {{(RESID_W-STEP_W){1'b0}}, pwm_step};
				entry.step     = pwm_step;
				entry.level_lo = coarse;
				entry.level_hi = coarse + LEVEL_W'(1);
			end
		endcase
	end

endmodule

// File: rtl/core/sdmpwm_queue.sv
// Short FIFO between the front end and the integrator back end.
module sdmpwm_queue
	import sdmpwm_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  qent_t  wr_data,
	input  logic   pop,
	output qent_t  rd_data,
	output qstat_t stat
);

	qent_t             mem [Q_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == (QPTR_W+1)'(Q_DEPTH));
	assign rd_data    = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end

endmodule

// File: rtl/core/sdmpwm_back.sv
// Back end: error integrator update, level choice and output register.
module sdmpwm_back
	import sdmpwm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  qent_t       head,
	input  logic        q_empty,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // [15:0] level, [16] dither_high, [23:17] zero
);

	localparam int SUM_W = ACC_BITS + 2;

	logic signed [ACC_BITS-1:0] integ_q;
	logic                       m_tvalid_q;
	logic [LEVEL_W-1:0]         level_q;
	logic                       high_q;

	logic [SUM_W-1:0]    t;
	logic [SUM_W-1:0]    step_ext;
	logic [SUM_W-1:0]    nxt;
	logic                high;
	logic                in_range;
	logic [ACC_BITS-1:0] integ_nxt;

	assign pop = !q_empty && (!m_tvalid_q || m_tready);

	assign t        = {{(SUM_W-ACC_BITS){integ_q[ACC_BITS-1]}}, integ_q}
	                + {{(SUM_W-RESID_W){head.resid[RESID_W-1]}}, head.resid};
	assign step_ext = {{(SUM_W-STEP_W){1'b0}}, head.step};
	assign high     = !t[SUM_W-1] && (t != '0);
	assign nxt      = high ? t - step_ext : t + step_ext;
	// Saturate when the bits above the integrator's sign bit disagree.
	assign in_range = (&nxt[SUM_W-1:ACC_BITS-1]) || !(|nxt[SUM_W-1:ACC_BITS-1]);
	assign integ_nxt = in_range ? nxt[ACC_BITS-1:0]
	                 : (nxt[SUM_W-1] ? {1'b1, {(ACC_BITS-1){1'b0}}}
	                                 : {1'b0, {(ACC_BITS-1){1'b1}}});

	always_ff @(posedge clk) begin
		if (pop) begin
			level_q <= high ? head.level_hi : head.level_lo;
			high_q  <= high;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (pop) begin
				integ_q    <= integ_nxt;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'd0, high_q, level_q};

endmodule
